/* hw/rtl/lzw_code_bit_packer_unit_assert.svh */
// assertion macros used by the packer drain rtl
`ifndef LZW_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define LZW_CODE_BIT_PACKER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LCBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcbp assertion failed");

// antecedent implies consequent in the next cycle
`define LCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcbp assertion failed");

`endif

/* hw/rtl/lcbp_pkg.sv */
package lcbp_pkg;

  localparam int CNT_W = 5;

  localparam logic [4:0]  START_WIDTH     = 5'd9;
  localparam logic [4:0]  WIDTH_CAP       = 5'd16;
  localparam logic [4:0]  MAX_BITS_RESET  = 5'd16;
  localparam logic [15:0] CLEAR_CODE      = 16'd256;

  localparam logic REQ_CODE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // load request from the packing stage to the byte drain
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } drain_ctl_t;

endpackage

/* hw/rtl/lcbp_pack.sv */
module lcbp_pack #(
  parameter int GROUP_BYTES = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [15:0]                  in_code,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [4:0]                   cfg_max_code_bits,
  input  logic                         drain_free,
  output lcbp_pkg::drain_ctl_t         ctl,
  output logic [GROUP_BYTES-1:0][7:0]  load_bytes
);
  import lcbp_pkg::*;

  logic                        hold_valid_r, hold_valid_nxt;
  logic                        hold_type_r;
  logic [15:0]                 hold_code_r;
  logic [4:0]                  max_bits_r;
  logic [4:0]                  width_r, width_nxt;
  logic [15:0]                 cnt_r, cnt_nxt;
  logic [GROUP_BYTES-1:0][7:0] acc_r, acc_nxt;

  logic [4:0]                  limit;
  logic [6:0]                  bitpos;
  logic [3:0]                  byte_at;
  logic [15:0]                 code_mask;
  logic [23:0]                 ins_val;
  logic [GROUP_BYTES-1:0][7:0] merged;
  logic                        is_finish;
  logic                        is_clear;
  logic [15:0]                 cnt_inc;
  logic                        emit;
  logic                        consume;
  logic [4:0]                  w_post;
  logic [15:0]                 c_post;
  logic                        grow;
  logic [7:0]                  fin_bits;
  logic [5:0]                  raw_count;
  logic [5:0]                  cap_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (max_bits_r < START_WIDTH) begin
      limit = START_WIDTH;
    end else if (max_bits_r > WIDTH_CAP) begin
      limit = WIDTH_CAP;
    end else begin
      limit = max_bits_r;
    end
  end

  // bit offset of this slot inside the group
  assign bitpos    = 7'(cnt_r[2:0]) * 7'(width_r);
  assign byte_at   = bitpos[6:3];
  assign code_mask = 16'((17'd1 << width_r) - 17'd1);
  assign ins_val   = 24'(hold_code_r & code_mask) << bitpos[2:0];

  always_comb begin
    for (int i = 0; i < GROUP_BYTES; i++) begin
      merged[i] = acc_r[i];
      for (int k = 0; k < 3; k++) begin
        if (6'(i) == 6'(byte_at) + 6'(k)) begin
          merged[i] = merged[i] | ins_val[8*k +: 8];
        end
      end
    end
  end

  assign is_finish = (hold_type_r == REQ_FINISH);
  assign is_clear  = (hold_code_r == CLEAR_CODE);
  assign cnt_inc   = cnt_r + 16'd1;
  assign fin_bits  = 8'(bitpos) + 8'd7;

  always_comb begin
    if (is_finish) begin
      raw_count = 6'(fin_bits[7:3]);
      emit      = (raw_count != 6'd0);
    end else begin
      raw_count = 6'(width_r);
      emit      = (cnt_inc[2:0] == 3'd0) || is_clear;
    end
    if (raw_count > 6'(GROUP_BYTES)) begin
      cap_count = 6'(GROUP_BYTES);
    end else begin
      cap_count = raw_count;
    end
  end

  assign consume  = hold_valid_r && (!emit || drain_free);
  assign in_ready = !hold_valid_r || consume;

  assign ctl.load   = consume && emit;
  assign ctl.count  = CNT_W'(cap_count);
  assign load_bytes = is_finish ? acc_r : merged;

  // width and count update for a code transaction
  always_comb begin
    w_post = is_clear ? START_WIDTH : width_r;
    c_post = is_clear ? 16'd0 : cnt_inc;
    grow   = (w_post < limit) && (c_post == (16'd1 << (w_post - 5'd1)));
  end

  always_comb begin
    width_nxt      = width_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    hold_valid_nxt = hold_valid_r;
    if (consume) begin
      hold_valid_nxt = 1'b0;
      if (is_finish) begin
        width_nxt = START_WIDTH;
        cnt_nxt   = 16'd0;
        acc_nxt   = '0;
      end else begin
        width_nxt = grow ? w_post + 5'd1 : w_post;
        cnt_nxt   = grow ? 16'd0 : c_post;
        acc_nxt   = emit ? '0 : merged;
      end
    end
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      max_bits_r   <= MAX_BITS_RESET;
      width_r      <= START_WIDTH;
      cnt_r        <= 16'd0;
      acc_r        <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      width_r      <= width_nxt;
      cnt_r        <= cnt_nxt;
      acc_r        <= acc_nxt;
      if (cfg_valid) begin
        max_bits_r <= cfg_max_code_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_type_r <= in_req_type;
      hold_code_r <= in_code;
    end
  end

endmodule

/* hw/rtl/lcbp_drain.sv */
`include "lzw_code_bit_packer_unit_assert.svh"

module lcbp_drain #(
  parameter int GROUP_BYTES = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcbp_pkg::drain_ctl_t         ctl,
  input  logic [GROUP_BYTES-1:0][7:0]  load_bytes,
  output logic                         drain_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last_byte
);
  import lcbp_pkg::*;

  logic [CNT_W-1:0]            left_r;
  logic [GROUP_BYTES-1:0][7:0] bytes_r;

  assign out_valid     = (left_r != '0);
  assign out_byte      = bytes_r[0];
  assign out_last_byte = (left_r == CNT_W'(1));
  // free when empty, or once the final byte of the current group leaves
  assign drain_free    = !out_valid || (out_last_byte && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (ctl.load) begin
      left_r <= ctl.count;
    end else if (out_valid && out_ready) begin
      left_r <= left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bytes_r <= load_bytes;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < GROUP_BYTES - 1; i++) begin
        bytes_r[i] <= bytes_r[i+1];
      end
    end
  end

  `LCBP_ASSERT_SAME(a_load_when_free, ctl.load, drain_free)
  `LCBP_ASSERT_SAME(a_load_nonempty, ctl.load, ctl.count != '0)
  `LCBP_ASSERT_NEXT(a_load_shows, ctl.load, out_valid)
  `LCBP_ASSERT_NEXT(a_group_continues,
    out_valid && out_ready && !out_last_byte && !ctl.load, out_valid)

endmodule

/* hw/rtl/lzw_code_bit_packer_unit.sv */
// channel  | direction | ports
// ---------+-----------+--------------------------------------------------
// in       | input     | in_valid, in_ready, in_req_type, in_code
// out      | output    | out_valid, out_ready, out_byte, out_last_byte
// cfg      | input     | cfg_valid, cfg_ready, cfg_max_code_bits
//
// a code transaction that fills no group leaves the input register without waiting
// a group emission sends code width bytes (9 to 16) out of the byte shift register,
// one byte per cycle while out_ready is high, overlapping the next transactions; a
// transaction that emits waits in the input register until the shift register has
// handed over its last byte. rst_n clears the packing state and sets max_code_bits
// to 16; cfg is always ready.
module lzw_code_bit_packer_unit #(
  parameter int GROUP_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_max_code_bits
);
  import lcbp_pkg::*;

  drain_ctl_t                  ctl;
  logic [GROUP_BYTES-1:0][7:0] load_bytes;
  logic                        drain_free;

  lcbp_pack #(
    .GROUP_BYTES(GROUP_BYTES)
  ) u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_code          (in_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_code_bits(cfg_max_code_bits),
    .drain_free       (drain_free),
    .ctl              (ctl),
    .load_bytes       (load_bytes)
  );

  lcbp_drain #(
    .GROUP_BYTES(GROUP_BYTES)
  ) u_drain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .load_bytes   (load_bytes),
    .drain_free   (drain_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

endmodule

/* verif/tb_lzw_code_bit_packer_unit.sv */
import lcbp_pkg::*;

typedef struct packed {
  logic [7:0] data;
  logic       last;
} packed_byte_t;

class lzw_pack_scoreboard;
  localparam int GROUP_BYTES = 20;

  logic [7:0]   group_buf [GROUP_BYTES];
  logic [4:0]   code_width;
  logic [15:0]  codes_at_width;
  logic [4:0]   max_bits;
  packed_byte_t pending_bytes [$];

  int unsigned mismatches;
  int unsigned bytes_checked;
  int unsigned codes_packed;
  int unsigned finishes;
  int unsigned clears;
  int unsigned widest;

  function new();
    max_bits = MAX_BITS_RESET;
    widest = START_WIDTH;
    reset_packing();
  endfunction

  function void reset_packing();
    foreach (group_buf[i]) group_buf[i] = 8'h00;
    code_width = START_WIDTH;
    codes_at_width = 16'd0;
  endfunction

  function void set_limit(logic [4:0] value);
    max_bits = value;
  endfunction

  // out-of-range limits clamp to the legal width span
  function logic [4:0] width_limit();
    if (max_bits < START_WIDTH) return START_WIDTH;
    if (max_bits > WIDTH_CAP) return WIDTH_CAP;
    return max_bits;
  endfunction

  function void emit_group(int unsigned count);
    int unsigned n;
    n = (count > GROUP_BYTES) ? GROUP_BYTES : count;
    for (int unsigned i = 0; i < n; i++)
      pending_bytes.push_back('{data: group_buf[i], last: (i + 1 == n)});
    foreach (group_buf[i]) group_buf[i] = 8'h00;
  endfunction

  function void note_request(logic req, logic [15:0] code);
    int unsigned bits;
    int unsigned bitpos;
    int unsigned byte_at;
    logic [15:0] mask;
    logic [23:0] shifted;
    if (req == REQ_FINISH) begin
      finishes++;
      bits = int'(codes_at_width[2:0]) * int'(code_width);
      emit_group((bits + 7) / 8);
      reset_packing();
      return;
    end
    codes_packed++;
    bitpos = int'(codes_at_width[2:0]) * int'(code_width);
    byte_at = bitpos / 8;
    mask = 16'((32'd1 << code_width) - 32'd1);
    shifted = {8'h00, code & mask} << (bitpos % 8);
    for (int unsigned k = 0; k < 3; k++)
      if (byte_at + k < GROUP_BYTES)
        group_buf[byte_at + k] = group_buf[byte_at + k] | shifted[8*k +: 8];
    codes_at_width = codes_at_width + 16'd1;
    // clear code is matched on all 16 bits, not the packed ones
    if (codes_at_width[2:0] == 3'd0 || code == CLEAR_CODE)
      emit_group(code_width);
    if (code == CLEAR_CODE) begin
      clears++;
      code_width = START_WIDTH;
      codes_at_width = 16'd0;
    end
    if (code_width < width_limit() &&
        codes_at_width == 16'(32'd1 << (code_width - 5'd1))) begin
      code_width = code_width + 5'd1;
      codes_at_width = 16'd0;
      if (code_width > widest) widest = code_width;
    end
  endfunction

  function void check_byte(logic [7:0] data, logic last);
    packed_byte_t want;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte %02h last %0d with nothing pending", data, last);
      return;
    end
    want = pending_bytes.pop_front();
    bytes_checked++;
    if (data !== want.data || last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("byte mismatch: expected %02h last %0d, got %02h last %0d",
                 want.data, want.last, data, last);
    end
  endfunction
endclass

module tb_lzw_code_bit_packer_unit;
  localparam int GROUP_BYTES = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_CODE;
  logic [15:0] in_code = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_max_code_bits = 5'd0;

  logic        idling_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned rx_pause = 0;

  lzw_pack_scoreboard sb = new();

  lzw_code_bit_packer_unit #(
    .GROUP_BYTES(GROUP_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_code          (in_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_code_bits(cfg_max_code_bits)
  );

  always #1 clk = ~clk;

  // receiver: random stall bursts, plus an occasional long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_pause <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      rx_pause <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_pause != 0) begin
      rx_pause <= rx_pause - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      rx_pause <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_max_code_bits);
      if (out_valid && out_ready) sb.check_byte(out_byte, out_last_byte);
      if (in_valid && in_ready) sb.note_request(in_req_type, in_code);
    end
  end

  task automatic send_item(input logic req, input logic [15:0] code);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_code(int unsigned clear_pct);
    int unsigned roll = $urandom_range(0, 99);
    logic [15:0] c;
    if (roll < clear_pct) return CLEAR_CODE;
    if (roll < 70) c = 16'($urandom_range(0, 4095));
    else c = 16'($urandom);
    // keep clear-free streams clear-free
    if (clear_pct == 0 && c == CLEAR_CODE) c = 16'h0101;
    return c;
  endfunction

  task automatic send_mixed(input int unsigned n, input int unsigned clear_pct,
                            input int unsigned finish_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < finish_pct) send_item(REQ_FINISH, 16'($urandom));
      else send_item(REQ_CODE, pick_code(clear_pct));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_max_code_bits <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(5'd16);
    idling_on <= 1'b1;

    // finish on an empty group, then a full group of edge-case codes
    send_item(REQ_FINISH, 16'hFFFF);
    send_item(REQ_CODE, 16'h0000);
    send_item(REQ_CODE, 16'hFFFF);
    send_item(REQ_CODE, 16'h01FF);
    send_item(REQ_CODE, 16'h8100);  // low bits look like clear but it is not
    send_item(REQ_CODE, 16'hAAAA);
    send_item(REQ_CODE, 16'h5555);
    send_item(REQ_CODE, 16'h0001);
    send_item(REQ_CODE, 16'h00FF);
    // partial group flushed by finish, code field ignored
    send_item(REQ_CODE, 16'h01FF);
    send_item(REQ_CODE, 16'h0000);
    send_item(REQ_CODE, 16'h0123);
    send_item(REQ_FINISH, CLEAR_CODE);
    // clear mid-group, at the first slot, and on the group's last slot
    send_item(REQ_CODE, 16'h00FF);
    send_item(REQ_CODE, 16'h01AB);
    send_item(REQ_CODE, CLEAR_CODE);
    send_item(REQ_CODE, CLEAR_CODE);
    for (int i = 0; i < 7; i++) send_item(REQ_CODE, 16'h01FF);
    send_item(REQ_CODE, CLEAR_CODE);
    send_item(REQ_FINISH, 16'h0000);
    wait_drained();

    // limit below range, with a long receiver hold to back the block up
    write_limit(5'd0);
    hold_requests <= hold_requests + 1;
    send_mixed(50, 4, 4);
    wait_drained();

    // long clear-free stream so the width grows to 10
    write_limit(5'd11);
    send_item(REQ_FINISH, 16'h0000);
    send_mixed(270, 0, 0);
    wait_drained();
    // lowering the limit must not shrink the width
    write_limit(5'd9);
    send_mixed(40, 0, 0);
    wait_drained();
    write_limit(5'd31);
    send_mixed(30, 0, 0);
    send_item(REQ_FINISH, 16'h0000);
    wait_drained();

    write_limit(5'd10);
    send_mixed(40, 2, 2);
    wait_drained();

    // closing stretch without idling
    idling_on <= 1'b0;
    write_limit(5'd20);
    send_mixed(30, 3, 3);
    send_item(REQ_FINISH, 16'h0000);
    wait_drained();

    $display("covered %0d codes, %0d clears, %0d finishes, widest width %0d",
             sb.codes_packed, sb.clears, sb.finishes, sb.widest);
    $display("%0d bytes checked, %0d mismatches", sb.bytes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("tb_lzw_code_bit_packer_unit: PASS");
    end else begin
      $display("tb_lzw_code_bit_packer_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the packer");
    $display("tb_lzw_code_bit_packer_unit: FAIL");
    $finish;
  end
endmodule
